// ----- hdl/tgcr_pkg.sv -----
`timescale 1ns / 1ps
package tgcr_pkg;

	localparam int POS_W = 48;
	localparam int SPD_W = 32;
	localparam int RADIUS_W = 20;
	localparam int GRID_DIM_W = 7;
	localparam int TILE_IDX_W = 6;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 20;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_LOADED = 2'd3;

	// Command codes of an input word.
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_RESOLVE = 1'b1;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 20'd65536;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_PASS,
		OP_RESOLVE
	} op_kind_t;

	typedef struct packed {
		logic cmd;
		logic [TILE_IDX_W-1:0] tile_col;
		logic [TILE_IDX_W-1:0] tile_row;
		logic tile_solid;
		logic signed [POS_W-1:0] prev_x;
		logic signed [POS_W-1:0] prev_y;
		logic signed [POS_W-1:0] moved_x;
		logic signed [POS_W-1:0] moved_y;
		logic signed [SPD_W-1:0] speed_x;
		logic signed [SPD_W-1:0] speed_y;
	} in_item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] final_x;
		logic signed [POS_W-1:0] final_y;
		logic signed [SPD_W-1:0] final_speed_x;
		logic signed [SPD_W-1:0] final_speed_y;
		logic hit_x;
		logic hit_y;
	} out_item_t;

	typedef struct packed {
		logic [GRID_DIM_W-1:0] grid_width;
		logic [GRID_DIM_W-1:0] grid_height;
		logic [RADIUS_W-1:0] radius;
		logic loaded;
	} cfg_t;

	typedef struct packed {
		op_kind_t kind;
		logic [TILE_IDX_W-1:0] tile_col;
		logic [TILE_IDX_W-1:0] tile_row;
		logic tile_solid;
		logic signed [POS_W-1:0] prev_x;
		logic signed [POS_W-1:0] prev_y;
		logic signed [POS_W-1:0] moved_x;
		logic signed [POS_W-1:0] moved_y;
		logic signed [SPD_W-1:0] speed_x;
		logic signed [SPD_W-1:0] speed_y;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t op;
	} head_t;

endpackage

// ----- hdl/tile_grid_collision_resolve.sv -----
`timescale 1ns / 1ps
// Resolves actor moves against a grid of solid tiles, one axis at a time.
// Words are taken with start while busy is low and wait in a two-entry queue;
// busy rises only when that queue is full. A resolve word produces exactly one
// result, shown for a single cycle with result_valid; the receiver cannot stall
// it, and results come out in the order the words were taken. A tile write
// produces nothing. A resolve runs the x test and then the y test; each sets
// up the box bounds, then reads the grid rows the box covers (three at the
// default radius) from the single-port tile row memory, which delivers one
// row per cycle; a hit ends its test early.
// The grid reads as all walkable right after reset with no clearing pass, since
// each row carries a valid flag.
module tile_grid_collision_resolve #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input tgcr_pkg::in_item_t in_item,
	output logic busy,
	output logic result_valid,
	output tgcr_pkg::out_item_t result,
	input logic cfg_we,
	input logic [tgcr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [tgcr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	tgcr_pkg::cfg_t cfg_q;
	tgcr_pkg::head_t head;
	logic pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width <= '0;
			cfg_q.grid_height <= '0;
			cfg_q.radius <= tgcr_pkg::RADIUS_RESET;
			cfg_q.loaded <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tgcr_pkg::CFG_GRID_WIDTH: cfg_q.grid_width <= cfg_wdata[tgcr_pkg::GRID_DIM_W-1:0];
				tgcr_pkg::CFG_GRID_HEIGHT: cfg_q.grid_height <= cfg_wdata[tgcr_pkg::GRID_DIM_W-1:0];
				tgcr_pkg::CFG_RADIUS: cfg_q.radius <= cfg_wdata[tgcr_pkg::RADIUS_W-1:0];
				tgcr_pkg::CFG_GRID_LOADED: cfg_q.loaded <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	tgcr_front #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_item(in_item),
		.loaded(cfg_q.loaded),
		.pop(pop),
		.busy(busy),
		.head(head)
	);

	tgcr_back #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.head(head),
		.pop(pop),
		.result_valid(result_valid),
		.result(result)
	);

	a_hit_x_zeroes_speed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit_x |-> result.final_speed_x == '0)
		else $error("x hit without zero x speed");

	a_hit_y_zeroes_speed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit_y |-> result.final_speed_y == '0)
		else $error("y hit without zero y speed");

	a_no_hit_unloaded: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !cfg_q.loaded |-> !result.hit_x && !result.hit_y)
		else $error("hit reported with no grid loaded");

	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

endmodule

// ----- hdl/tgcr_front.sv -----
`timescale 1ns / 1ps
module tgcr_front #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input tgcr_pkg::in_item_t in_item,
	input logic loaded,
	input logic pop,
	output logic busy,
	output tgcr_pkg::head_t head
);

	localparam int QDEPTH = 2;
	localparam int PTR_W = $clog2(QDEPTH);
	localparam int CNT_W = $clog2(QDEPTH + 1);

	tgcr_pkg::op_t queue_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	tgcr_pkg::op_t op_in;
	logic keep;
	logic push;
	logic do_pop;

	// A tile write that falls outside the store has no effect, so it is
	// dropped here and never reaches the queue.
	always_comb begin
		op_in.tile_col = in_item.tile_col;
		op_in.tile_row = in_item.tile_row;
		op_in.tile_solid = in_item.tile_solid;
		op_in.prev_x = in_item.prev_x;
		op_in.prev_y = in_item.prev_y;
		op_in.moved_x = in_item.moved_x;
		op_in.moved_y = in_item.moved_y;
		op_in.speed_x = in_item.speed_x;
		op_in.speed_y = in_item.speed_y;
		keep = 1'b1;
		if (in_item.cmd == tgcr_pkg::CMD_WRITE) begin
			op_in.kind = tgcr_pkg::OP_WRITE;
			keep = (int'(in_item.tile_col) < MAX_COLS) && (int'(in_item.tile_row) < MAX_ROWS);
		end else if (loaded) begin
			op_in.kind = tgcr_pkg::OP_RESOLVE;
		end else begin
			op_in.kind = tgcr_pkg::OP_PASS;
		end
	end

	assign busy = (count_q == CNT_W'(QDEPTH));
	assign push = start && !busy && keep;
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.op = queue_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= op_in;
		end
	end

endmodule

// ----- hdl/tgcr_back.sv -----
`timescale 1ns / 1ps
module tgcr_back #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 64,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input tgcr_pkg::cfg_t cfg,
	input tgcr_pkg::head_t head,
	output logic pop,
	output logic result_valid,
	output tgcr_pkg::out_item_t result
);

	// Writes can only reach the first 64 rows and columns; tiles beyond that
	// are never solid and need no storage.
	localparam int STORE_COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
	localparam int STORE_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;
	localparam int CAW = (STORE_COLS > 1) ? $clog2(STORE_COLS) : 1;
	localparam int RAW = (STORE_ROWS > 1) ? $clog2(STORE_ROWS) : 1;
	localparam int CAP_COLS = (MAX_COLS < 127) ? MAX_COLS : 127;
	localparam int CAP_ROWS = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int SUM_W = tgcr_pkg::POS_W + 1;
	localparam int TW = SUM_W - FRAC_BITS;
	localparam int DW = tgcr_pkg::GRID_DIM_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_SCAN
	} state_t;

	state_t state_q;
	tgcr_pkg::op_t op_q;
	logic axis_q;
	logic hit_x_q;
	logic signed [tgcr_pkg::POS_W-1:0] cur_x_q;
	logic signed [TW-1:0] x0_q;
	logic signed [TW-1:0] x1_q;
	logic signed [TW-1:0] y1_q;
	logic signed [TW-1:0] ty_q;
	logic rd_v_s1;
	logic rowok_s1;
	logic [STORE_COLS-1:0] rd_data_s1;
	logic result_valid_q;
	tgcr_pkg::out_item_t result_q;

	logic [STORE_COLS-1:0] tiles_mem [STORE_ROWS];
	logic [STORE_ROWS-1:0] row_valid_q;

	logic [DW-1:0] wsat;
	logic [DW-1:0] hsat;
	logic signed [tgcr_pkg::POS_W-1:0] cy;
	logic signed [SUM_W-1:0] rad_ext;
	logic signed [SUM_W-1:0] xlo;
	logic signed [SUM_W-1:0] xhi;
	logic signed [SUM_W-1:0] ylo;
	logic signed [SUM_W-1:0] yhi;
	logic signed [TW-1:0] tx0;
	logic signed [TW-1:0] tx1;
	logic signed [TW-1:0] ty0;
	logic signed [TW-1:0] ty1;
	logic signed [TW-1:0] wm1;
	logic signed [TW-1:0] hm1;
	logic signed [TW-1:0] x0c;
	logic signed [TW-1:0] x1c;
	logic signed [TW-1:0] y0c;
	logic signed [TW-1:0] y1c;
	logic [STORE_COLS-1:0] col_mask;
	logic issue;
	logic in_range;
	logic hit_now;
	logic box_done;
	logic wr_en;
	logic [RAW-1:0] wr_row;
	logic [CAW-1:0] wr_col;
	logic [RAW-1:0] rd_row;
	logic [STORE_COLS-1:0] wr_fresh;

	assign wsat = (cfg.grid_width > DW'(CAP_COLS)) ? DW'(CAP_COLS) : cfg.grid_width;
	assign hsat = (cfg.grid_height > DW'(CAP_ROWS)) ? DW'(CAP_ROWS) : cfg.grid_height;
	assign wm1 = $signed({{(TW - DW){1'b0}}, wsat}) - $signed(TW'(1));
	assign hm1 = $signed({{(TW - DW){1'b0}}, hsat}) - $signed(TW'(1));

	// Box bounds around the current center; the upper bits of each sum are
	// the tile index, rounded toward minus infinity.
	assign cy = axis_q ? op_q.moved_y : op_q.prev_y;
	assign rad_ext = $signed({{(SUM_W - tgcr_pkg::RADIUS_W){1'b0}}, cfg.radius});
	assign xlo = $signed({cur_x_q[tgcr_pkg::POS_W-1], cur_x_q}) - rad_ext;
	assign xhi = $signed({cur_x_q[tgcr_pkg::POS_W-1], cur_x_q}) + rad_ext;
	assign ylo = $signed({cy[tgcr_pkg::POS_W-1], cy}) - rad_ext;
	assign yhi = $signed({cy[tgcr_pkg::POS_W-1], cy}) + rad_ext;
	assign tx0 = xlo[SUM_W-1:FRAC_BITS];
	assign tx1 = xhi[SUM_W-1:FRAC_BITS];
	assign ty0 = ylo[SUM_W-1:FRAC_BITS];
	assign ty1 = yhi[SUM_W-1:FRAC_BITS];
	assign x0c = (tx0 < 0) ? '0 : tx0;
	assign y0c = (ty0 < 0) ? '0 : ty0;
	assign x1c = (tx1 > wm1) ? wm1 : tx1;
	assign y1c = (ty1 > hm1) ? hm1 : ty1;

	always_comb begin
		for (int c = 0; c < STORE_COLS; c++) begin
			col_mask[c] = ($signed(TW'(c)) >= x0_q) && ($signed(TW'(c)) <= x1_q);
		end
	end

	// One row is read per cycle; the row read in the previous cycle is checked
	// against the column range while the next one is fetched.
	assign issue = (state_q == ST_SCAN) && (ty_q <= y1_q);
	assign in_range = (ty_q < $signed(TW'(STORE_ROWS)));
	assign rd_row = ty_q[RAW-1:0];
	assign hit_now = rd_v_s1 && rowok_s1 && (|(rd_data_s1 & col_mask));
	assign box_done = hit_now || (ty_q > y1_q);

	assign pop = (state_q == ST_IDLE) && head.valid;
	assign wr_en = pop && (head.op.kind == tgcr_pkg::OP_WRITE);
	assign wr_row = head.op.tile_row[RAW-1:0];
	assign wr_col = head.op.tile_col[CAW-1:0];

	always_comb begin
		wr_fresh = '0;
		wr_fresh[wr_col] = head.op.tile_solid;
	end

	// A row not yet written since reset reads as all walkable; its first
	// write stores the whole row.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (row_valid_q[wr_row]) begin
				tiles_mem[wr_row][wr_col] <= head.op.tile_solid;
			end else begin
				tiles_mem[wr_row] <= wr_fresh;
			end
		end
		if (issue) begin
			rd_data_s1 <= tiles_mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rowok_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (issue) begin
				rowok_s1 <= in_range && row_valid_q[rd_row];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_v_s1 <= 1'b0;
			result_valid_q <= 1'b0;
			axis_q <= 1'b0;
			hit_x_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						case (head.op.kind)
							tgcr_pkg::OP_PASS: begin
								result_valid_q <= 1'b1;
								result_q.final_x <= head.op.moved_x;
								result_q.final_y <= head.op.moved_y;
								result_q.final_speed_x <= head.op.speed_x;
								result_q.final_speed_y <= head.op.speed_y;
								result_q.hit_x <= 1'b0;
								result_q.hit_y <= 1'b0;
							end
							tgcr_pkg::OP_RESOLVE: begin
								op_q <= head.op;
								cur_x_q <= head.op.moved_x;
								axis_q <= 1'b0;
								hit_x_q <= 1'b0;
								state_q <= ST_SETUP;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SETUP: begin
					x0_q <= x0c;
					x1_q <= x1c;
					y1_q <= y1c;
					ty_q <= y0c;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					rd_v_s1 <= issue;
					if (issue) begin
						ty_q <= ty_q + $signed(TW'(1));
					end
					if (box_done) begin
						if (!axis_q) begin
							if (hit_now) begin
								cur_x_q <= op_q.prev_x;
							end
							hit_x_q <= hit_now;
							axis_q <= 1'b1;
							state_q <= ST_SETUP;
						end else begin
							result_valid_q <= 1'b1;
							result_q.final_x <= cur_x_q;
							result_q.final_y <= hit_now ? op_q.prev_y : op_q.moved_y;
							result_q.final_speed_x <= hit_x_q ? '0 : op_q.speed_x;
							result_q.final_speed_y <= hit_now ? '0 : op_q.speed_y;
							result_q.hit_x <= hit_x_q;
							result_q.hit_y <= hit_now;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
